@@ rtl/eddi_pkg.sv @@
// Shared types, constants and helpers for the edge-directed diagonal interpolator.
// No dependencies; imported by edge_directed_diagonal_interpolator_unit.
package eddi_pkg;

  // Q16 luma weights (0.2126, 0.7152, 0.0722), summing to one.
  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  localparam logic [15:0] SHARP_RESET = 16'd8496;
  localparam logic [16:0] Q16_HALF    = 17'd32768;
  localparam logic [24:0] Q16_ROUND   = 25'd65535;

  // Register map, indexed by paddr[2].
  localparam logic REG_EDGE_SET = 1'b0;
  localparam logic REG_SHARP    = 1'b1;

  localparam int NUM_PIX = 16;
  localparam int NUM_GRP = 6;

  typedef logic [23:0] luma_t;
  typedef logic [25:0] grp_t;
  typedef logic signed [26:0] gdiff_t;
  typedef logic signed [30:0] edge_t;

  // Per-channel tap sums and center range for one window.
  typedef struct packed {
    logic [8:0] om;  // main diagonal outer taps
    logic [8:0] im;  // main diagonal inner taps
    logic [8:0] oa;  // anti-diagonal outer taps
    logic [8:0] ia;  // anti-diagonal inner taps
    logic [7:0] mn;
    logic [7:0] mx;
  } chan_t;

  // Taps of the chosen diagonal plus the center range.
  typedef struct packed {
    logic [8:0] outer;
    logic [8:0] inner;
    logic [7:0] mn;
    logic [7:0] mx;
  } tap_t;

  typedef struct packed {
    logic [24:0] p_out;
    logic [25:0] p_in;
    logic [7:0]  mn;
    logic [7:0]  mx;
  } prod_t;

  function automatic luma_t absdiff(input luma_t p, input luma_t q);
    return (p > q) ? (p - q) : (q - p);
  endfunction

  function automatic logic [7:0] min2(input logic [7:0] p, input logic [7:0] q);
    return (q < p) ? q : p;
  endfunction

  function automatic logic [7:0] max2(input logic [7:0] p, input logic [7:0] q);
    return (q > p) ? q : p;
  endfunction

endpackage

@@ rtl/edge_directed_diagonal_interpolator_unit.sv @@
// Top level of the edge-directed diagonal interpolator: a six-stage pixel pipeline
// and its register port. Depends on eddi_pkg.
//
// Usage. Each transfer on the slave stream (s_tvalid, s_tready, s_tdata) carries one
// 4x4 window of 24-bit RGB pixels, row by row, pixel [r][c] at bits (r*4+c)*24 +: 24,
// red in the top byte. Each transfer on the master stream (m_tvalid, m_tready, m_tdata)
// carries the interpolated pixel and a flag that tells which diagonal was followed.
// The luma-based edge test picks the interpolation direction; the result is a
// four-tap filter along that diagonal, clamped to the range of the four center pixels.
//
// A window accepted on the slave stream passes six register stages, the last of which
// is the output register that drives m_tdata. The pipeline takes one window every
// cycle while it is not stalled; its rate is set by the single shared stage enable,
// which lets all six stages advance together whenever the output register is empty
// or being read. When the receiver holds m_tready low with a result waiting, the
// whole pipeline freezes and s_tready drops in the same cycle, so nothing is lost
// or repeated.
//
// Reset (rst, synchronous, active high) empties the pipeline and returns the registers
// to edge_weight_set = 0 and sharpness_weight = 8496. Registers sit on the APB port at
// byte addresses 0 and 4 and are to be written only while the pipeline is empty.
module edge_directed_diagonal_interpolator_unit
  import eddi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // pixels_00_01, pixels_02_03, pixels_10_11, pixels_12_13,
  // pixels_20_21, pixels_22_23, pixels_30_31, pixels_32_33 (48 bits each)
  input  logic [383:0] s_tdata,
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], main_diagonal_used[24], zeros
  output logic [31:0]  m_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes decode on the word index only.
  // ---------------------------------------------------------------------------
  logic        edge_weight_set;
  logic [15:0] sharpness_weight;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_weight_set  <= 1'b0;
      sharpness_weight <= SHARP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_EDGE_SET: edge_weight_set  <= pwdata[0];
        REG_SHARP:    sharpness_weight <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EDGE_SET: prdata = {31'd0, edge_weight_set};
      REG_SHARP:    prdata = {16'd0, sharpness_weight};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages move together when the output register can take
  // a new value.
  // ---------------------------------------------------------------------------
  logic       adv;
  logic [6:1] vld;

  assign adv      = !vld[6] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:1], s_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: luma of every pixel, per-channel tap sums and center min/max.
  // ---------------------------------------------------------------------------
  luma_t      y_c [NUM_PIX];
  logic [7:0] ch_c [3][NUM_PIX];
  chan_t      chan_c [3];

  always_comb begin
    for (int k = 0; k < NUM_PIX; k++) begin
      ch_c[0][k] = s_tdata[k*24+16 +: 8];
      ch_c[1][k] = s_tdata[k*24+8 +: 8];
      ch_c[2][k] = s_tdata[k*24 +: 8];
      y_c[k] = 24'(LUMA_WR) * 24'(ch_c[0][k]) + 24'(LUMA_WG) * 24'(ch_c[1][k])
             + 24'(LUMA_WB) * 24'(ch_c[2][k]);
    end
    // Pixel [r][c] sits at index r*4+c.
    for (int c = 0; c < 3; c++) begin
      chan_c[c].om = 9'(ch_c[c][0])  + 9'(ch_c[c][15]);
      chan_c[c].im = 9'(ch_c[c][5])  + 9'(ch_c[c][10]);
      chan_c[c].oa = 9'(ch_c[c][3])  + 9'(ch_c[c][12]);
      chan_c[c].ia = 9'(ch_c[c][6])  + 9'(ch_c[c][9]);
      chan_c[c].mn = min2(min2(ch_c[c][5], ch_c[c][9]), min2(ch_c[c][6], ch_c[c][10]));
      chan_c[c].mx = max2(max2(ch_c[c][5], ch_c[c][9]), max2(ch_c[c][6], ch_c[c][10]));
    end
  end

  luma_t y1 [NUM_PIX];
  chan_t chan1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      y1    <= y_c;
      chan1 <= chan_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: absolute luma differences, summed into the six weight groups of
  // each diagonal.
  // ---------------------------------------------------------------------------
  grp_t g1_c [NUM_GRP];
  grp_t g2_c [NUM_GRP];

  always_comb begin
    g1_c[0] = 26'(absdiff(y1[2], y1[5]))  + 26'(absdiff(y1[5], y1[8]))
            + 26'(absdiff(y1[7], y1[10])) + 26'(absdiff(y1[10], y1[13]));
    g1_c[1] = 26'(absdiff(y1[3], y1[6]))  + 26'(absdiff(y1[9], y1[12]));
    g1_c[2] = 26'(absdiff(y1[3], y1[9]))  + 26'(absdiff(y1[6], y1[12]));
    g1_c[3] = 26'(absdiff(y1[6], y1[9]));
    g1_c[4] = 26'(absdiff(y1[2], y1[8]))  + 26'(absdiff(y1[7], y1[13]));
    g1_c[5] = 26'(absdiff(y1[1], y1[4]))  + 26'(absdiff(y1[11], y1[14]));

    g2_c[0] = 26'(absdiff(y1[1], y1[6]))  + 26'(absdiff(y1[6], y1[11]))
            + 26'(absdiff(y1[4], y1[9]))  + 26'(absdiff(y1[9], y1[14]));
    g2_c[1] = 26'(absdiff(y1[0], y1[5]))  + 26'(absdiff(y1[10], y1[15]));
    g2_c[2] = 26'(absdiff(y1[0], y1[10])) + 26'(absdiff(y1[5], y1[15]));
    g2_c[3] = 26'(absdiff(y1[5], y1[10]));
    g2_c[4] = 26'(absdiff(y1[4], y1[14])) + 26'(absdiff(y1[1], y1[11]));
    g2_c[5] = 26'(absdiff(y1[2], y1[7]))  + 26'(absdiff(y1[8], y1[13]));
  end

  grp_t  g1 [NUM_GRP];
  grp_t  g2 [NUM_GRP];
  chan_t chan2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      g1    <= g1_c;
      g2    <= g2_c;
      chan2 <= chan1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-group difference between the two diagonals.
  // ---------------------------------------------------------------------------
  gdiff_t gd [NUM_GRP];
  chan_t  chan3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_GRP; k++) begin
        gd[k] <= gdiff_t'({1'b0, g1[k]}) - gdiff_t'({1'b0, g2[k]});
      end
      chan3 <= chan2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: weighted edge difference and direction choice. A tie goes to the
  // anti-diagonal.
  // ---------------------------------------------------------------------------
  edge_t e0, e1, e2, e3, e4, e5, edge_diff;
  logic  main_c;
  tap_t  tap_c [3];

  always_comb begin
    e0 = edge_t'(gd[0]);
    e1 = edge_t'(gd[1]);
    e2 = edge_t'(gd[2]);
    e3 = edge_t'(gd[3]);
    e4 = edge_t'(gd[4]);
    e5 = edge_t'(gd[5]);
    if (edge_weight_set) begin
      edge_diff = e0 <<< 1;
    end else begin
      edge_diff = (e0 <<< 1) + e1 - e2 + (e3 <<< 2) - e4 + e5;
    end
    main_c = (edge_diff > 0);
    for (int c = 0; c < 3; c++) begin
      tap_c[c].outer = main_c ? chan3[c].om : chan3[c].oa;
      tap_c[c].inner = main_c ? chan3[c].im : chan3[c].ia;
      tap_c[c].mn    = chan3[c].mn;
      tap_c[c].mx    = chan3[c].mx;
    end
  end

  logic main4;
  tap_t tap4 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      main4 <= main_c;
      tap4  <= tap_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: the two filter products per channel, in Q16.
  // ---------------------------------------------------------------------------
  logic [16:0] inner_wt;
  prod_t       prod_c [3];

  always_comb begin
    inner_wt = Q16_HALF + 17'(sharpness_weight);
    for (int c = 0; c < 3; c++) begin
      prod_c[c].p_out = 25'(sharpness_weight) * 25'(tap4[c].outer);
      prod_c[c].p_in  = 26'(inner_wt) * 26'(tap4[c].inner);
      prod_c[c].mn    = tap4[c].mn;
      prod_c[c].mx    = tap4[c].mx;
    end
  end

  logic  main5;
  prod_t prod5 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      main5 <= main4;
      prod5 <= prod_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: combine, clamp to the center range, round up, into the output register.
  // ---------------------------------------------------------------------------
  logic signed [26:0] v_c [3];
  logic signed [26:0] lo_c [3];
  logic signed [26:0] hi_c [3];
  logic signed [26:0] vc_c [3];
  logic [24:0]        rnd_c [3];
  logic [7:0]         pix_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_c[c]  = 27'(prod5[c].p_in) - 27'(prod5[c].p_out);
      lo_c[c] = 27'({prod5[c].mn, 16'd0});
      hi_c[c] = 27'({prod5[c].mx, 16'd0});
      if (v_c[c] < lo_c[c]) begin
        vc_c[c] = lo_c[c];
      end else if (v_c[c] > hi_c[c]) begin
        vc_c[c] = hi_c[c];
      end else begin
        vc_c[c] = v_c[c];
      end
      // The clamped value is non-negative and at most 255.0, so bits 23:16 hold it.
      rnd_c[c] = 25'(vc_c[c]) + Q16_ROUND;
      pix_c[c] = rnd_c[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {7'd0, main5, pix_c[2], pix_c[1], pix_c[0]};
    end
  end

endmodule
